@@ src/elementary_cycle_enumerator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef ELEMENTARY_CYCLE_ENUMERATOR_DEFINES_SVH
`define ELEMENTARY_CYCLE_ENUMERATOR_DEFINES_SVH

// Checked only while out of reset.
`define ECE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ECE_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ece_pkg.sv @@
package ece_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int CMD_DEPTH        = 2;
  localparam int RES_DEPTH        = 2;
  localparam int FIELD_W          = 5;
  localparam logic [FIELD_W-1:0] VCOUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_NEXT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_FLAG
  } eng_state_t;

  typedef struct packed {
    op_t               op;
    logic              edge_ok;
    logic [FIELD_W-1:0] u;
    logic [FIELD_W-1:0] v;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] vertex;
    logic [FIELD_W-1:0] position;
    logic               last;
    logic               done_res;
  } res_t;

endpackage

@@ src/elementary_cycle_enumerator.sv @@
// Edge add / clear: the acknowledge goes through the command queue, the engine's flag
// state and the result queue. Next-cycle request: the engine searches step by step until a
// step closes a cycle, then writes its vertices one per cycle while the result queue has room.
// Throughput is one request at a time, bounded by the engine's search loop.
// Reset (rst_n low, synchronous) clears the graph, the search, both queues and
// sets vertex_count to 16.
module elementary_cycle_enumerator #(
  parameter int MAX_VERTICES = ece_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  in_opcode,
  input  logic [ece_pkg::FIELD_W-1:0] in_edge_u,
  input  logic [ece_pkg::FIELD_W-1:0] in_edge_v,
  output logic                        empty,
  input  logic                        pop,
  output logic [ece_pkg::FIELD_W-1:0] out_vertex,
  output logic [ece_pkg::FIELD_W-1:0] out_position,
  output logic                        out_last,
  output logic                        out_done_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [ece_pkg::FIELD_W-1:0] vcount_r, vcount_nxt;
  logic          cfg_wr;
  logic          cmd_wr, cmd_full, cmd_empty, cmd_rd;
  ece_pkg::cmd_t cmd_in, cmd_out;
  logic          res_wr, res_full;
  ece_pkg::res_t res_in, res_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, vcount_r} : 32'd0;
  assign vcount_nxt = cfg_wr ? pwdata[ece_pkg::FIELD_W-1:0] : vcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= ece_pkg::VCOUNT_RESET;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  ece_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .push      (push),
    .full      (full),
    .in_opcode (in_opcode),
    .in_edge_u (in_edge_u),
    .in_edge_v (in_edge_v),
    .cmd_full  (cmd_full),
    .cmd_wr    (cmd_wr),
    .cmd_data  (cmd_in)
  );

  ece_fifo #(.WIDTH($bits(ece_pkg::cmd_t)), .DEPTH(ece_pkg::CMD_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  ece_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_count (vcount_r),
    .cfg_restart  (cfg_wr),
    .cmd_empty    (cmd_empty),
    .cmd_data     (cmd_out),
    .cmd_rd       (cmd_rd),
    .res_full     (res_full),
    .res_wr       (res_wr),
    .res_data     (res_in)
  );

  ece_fifo #(.WIDTH($bits(ece_pkg::res_t)), .DEPTH(ece_pkg::RES_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_vertex   = res_out.vertex;
  assign out_position = res_out.position;
  assign out_last     = res_out.last;
  assign out_done_res = res_out.done_res;

endmodule

@@ src/ece_fifo.sv @@
module ece_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/ece_front.sv @@
module ece_front #(
  parameter int MAX_VERTICES = ece_pkg::MAX_VERTICES_DEF
) (
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  in_opcode,
  input  logic [ece_pkg::FIELD_W-1:0] in_edge_u,
  input  logic [ece_pkg::FIELD_W-1:0] in_edge_v,
  input  logic                        cmd_full,
  output logic                        cmd_wr,
  output ece_pkg::cmd_t               cmd_data
);

  ece_pkg::op_t op;
  logic         u_ok, v_ok;

  assign op   = ece_pkg::op_t'(in_opcode);
  assign full = cmd_full;

  // endpoints are 1-based; zero or beyond the vertex capacity is dropped
  assign u_ok = (in_edge_u != '0) && (int'(in_edge_u) <= MAX_VERTICES);
  assign v_ok = (in_edge_v != '0) && (int'(in_edge_v) <= MAX_VERTICES);

  always_comb begin
    cmd_data.op      = op;
    cmd_data.edge_ok = u_ok && v_ok && (in_edge_u != in_edge_v);
    cmd_data.u       = in_edge_u;
    cmd_data.v       = in_edge_v;
    cmd_wr           = push && !cmd_full && (op != ece_pkg::OP_NONE);
  end

endmodule

@@ src/ece_engine.sv @@
module ece_engine #(
  parameter int MAX_VERTICES = ece_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ece_pkg::FIELD_W-1:0] vertex_count,
  input  logic                        cfg_restart,
  input  logic                        cmd_empty,
  input  ece_pkg::cmd_t               cmd_data,
  output logic                        cmd_rd,
  input  logic                        res_full,
  output logic                        res_wr,
  output ece_pkg::res_t               res_data
);

  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int CW = $clog2(MAX_VERTICES + 2);
  localparam int RW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  ece_pkg::eng_state_t state_r, state_nxt;

  logic [MAX_VERTICES-1:0] adj_r   [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_nxt [MAX_VERTICES];
  logic [VW-1:0] stack_r   [MAX_VERTICES+1];
  logic [VW-1:0] stack_nxt [MAX_VERTICES+1];
  logic [VW-1:0] depth_r, depth_nxt;
  logic [VW-1:0] emit_r, emit_nxt;
  logic          started_r, started_nxt;
  logic          finished_r, finished_nxt;

  logic [CW-1:0] n_lim, cand;
  logic [VW-1:0] cur, prev;
  logic [RW-1:0] row_idx, col_idx, ua, va;
  logic [MAX_VERTICES-1:0] adj_row;
  logic          adj_hit, repeated, at_root, over_n, closes, can_close, stack_top;
  logic          search_emit, search_done;

  assign n_lim = (int'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                     : CW'(vertex_count);
  assign cur     = stack_r[depth_r];
  assign prev    = stack_r[VW'(depth_r - VW'(1))];
  assign cand    = CW'(cur) + CW'(1);
  assign row_idx = RW'(prev - VW'(1));
  assign col_idx = RW'(cand - CW'(1));
  assign adj_row = adj_r[row_idx];
  assign adj_hit = adj_row[col_idx];
  assign at_root = (depth_r == '0);
  assign over_n  = (cand > n_lim);
  assign closes  = (VW'(cand) == stack_r[0]);
  assign can_close = (int'(depth_r) >= 3);
  assign stack_top = (int'(depth_r) >= MAX_VERTICES);
  assign ua = RW'(cmd_data.u - ece_pkg::FIELD_W'(1));
  assign va = RW'(cmd_data.v - ece_pkg::FIELD_W'(1));

  // candidate already on the path between the start and the current depth
  always_comb begin
    repeated = 1'b0;
    for (int i = 1; i <= MAX_VERTICES; i++) begin
      if ((i < int'(depth_r)) && (stack_r[i] == VW'(cand))) begin
        repeated = 1'b1;
      end
    end
  end

  assign search_done = over_n && at_root;
  assign search_emit = !over_n && !at_root && adj_hit && closes && can_close;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ece_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_data.op == ece_pkg::OP_NEXT && !finished_r) begin
            state_nxt = ece_pkg::ST_SEARCH;
          end else begin
            state_nxt = ece_pkg::ST_FLAG;
          end
        end
      end
      ece_pkg::ST_SEARCH: begin
        if (search_done) begin
          state_nxt = ece_pkg::ST_FLAG;
        end else if (search_emit) begin
          state_nxt = ece_pkg::ST_EMIT;
        end
      end
      ece_pkg::ST_EMIT: begin
        if (!res_full && emit_r == depth_r) begin
          state_nxt = ece_pkg::ST_IDLE;
        end
      end
      ece_pkg::ST_FLAG: begin
        if (!res_full) begin
          state_nxt = ece_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ece_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    adj_nxt      = adj_r;
    stack_nxt    = stack_r;
    depth_nxt    = depth_r;
    emit_nxt     = emit_r;
    started_nxt  = started_r;
    finished_nxt = finished_r;
    cmd_rd       = 1'b0;
    res_wr       = 1'b0;
    res_data     = '0;
    case (state_r)
      ece_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_rd = 1'b1;
          case (cmd_data.op)
            ece_pkg::OP_ADD, ece_pkg::OP_CLEAR: begin
              if (cmd_data.op == ece_pkg::OP_CLEAR) begin
                for (int r = 0; r < MAX_VERTICES; r++) begin
                  adj_nxt[r] = '0;
                end
              end else if (cmd_data.edge_ok) begin
                adj_nxt[ua][va] = 1'b1;
                adj_nxt[va][ua] = 1'b1;
              end
              started_nxt  = 1'b0;
              finished_nxt = 1'b0;
              depth_nxt    = '0;
              for (int s = 0; s <= MAX_VERTICES; s++) begin
                stack_nxt[s] = '0;
              end
            end
            ece_pkg::OP_NEXT: begin
              if (!finished_r && !started_r) begin
                started_nxt  = 1'b1;
                depth_nxt    = '0;
                stack_nxt[0] = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ece_pkg::ST_SEARCH: begin
        if (over_n) begin
          stack_nxt[depth_r] = '0;
          if (at_root) begin
            finished_nxt = 1'b1;
          end else begin
            depth_nxt = depth_r - VW'(1);
          end
        end else begin
          stack_nxt[depth_r] = VW'(cand);
          if (at_root) begin
            depth_nxt    = VW'(1);
            stack_nxt[1] = '0;
          end else if (adj_hit && !closes && !repeated && !stack_top) begin
            depth_nxt = depth_r + VW'(1);
            stack_nxt[VW'(depth_r + VW'(1))] = '0;
          end
        end
        emit_nxt = '0;
      end
      ece_pkg::ST_EMIT: begin
        res_wr            = !res_full;
        res_data.vertex   = ece_pkg::FIELD_W'(stack_r[emit_r]);
        res_data.position = ece_pkg::FIELD_W'(emit_r);
        res_data.last     = (emit_r == depth_r);
        if (!res_full) begin
          emit_nxt = emit_r + VW'(1);
        end
      end
      ece_pkg::ST_FLAG: begin
        res_wr            = !res_full;
        res_data.last     = 1'b1;
        res_data.done_res = 1'b1;
      end
      default: ;
    endcase
    if (cfg_restart) begin
      started_nxt  = 1'b0;
      finished_nxt = 1'b0;
      depth_nxt    = '0;
      for (int s = 0; s <= MAX_VERTICES; s++) begin
        stack_nxt[s] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ece_pkg::ST_IDLE;
      depth_r    <= '0;
      emit_r     <= '0;
      started_r  <= 1'b0;
      finished_r <= 1'b0;
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj_r[r] <= '0;
      end
      for (int s = 0; s <= MAX_VERTICES; s++) begin
        stack_r[s] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      depth_r    <= depth_nxt;
      emit_r     <= emit_nxt;
      started_r  <= started_nxt;
      finished_r <= finished_nxt;
      adj_r      <= adj_nxt;
      stack_r    <= stack_nxt;
    end
  end

endmodule

@@ src/ece_checker.sv @@
`include "elementary_cycle_enumerator_defines.svh"

module ece_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input logic                        pop,
  input logic [ece_pkg::FIELD_W-1:0] out_vertex,
  input logic [ece_pkg::FIELD_W-1:0] out_position,
  input logic                        out_last,
  input logic                        out_done_res
);

  `ECE_ASSERT_ANY(a_reset_empty, !rst_n |=> empty, "result queue not empty after reset")
  `ECE_ASSERT_CLK(a_hold, !empty && !pop |=> !empty && $stable(out_vertex), "stalled result moved")
  `ECE_ASSERT_CLK(a_done_form, !empty && out_done_res |-> out_vertex == '0 && out_position == '0 && out_last, "malformed done result")
  `ECE_ASSERT_CLK(a_path_vertex, !empty && !out_done_res |-> out_vertex != '0, "cycle vertex is zero")

endmodule

bind elementary_cycle_enumerator ece_checker u_ece_checker (.*);
